// ===== rtl/core/bats_pkg.sv =====
// shared types, constants and widths for the brightness average threshold switch
// no dependencies; used by every module of the block

package bats_pkg;

  localparam int SAMPLES   = 8;
  localparam int POS_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int FILL_W    = $clog2(SAMPLES + 1);
  localparam int READ_MAX  = 200;
  localparam int SUM_W     = $clog2(READ_MAX * SAMPLES + 1);
  localparam int CNT_W     = $clog2(SUM_W + 1);

  localparam int LEVEL_W   = 8;
  localparam int RAW_W     = 16;
  localparam int TICK_W    = 15;
  localparam int IN_W      = 48;
  localparam int OUT_W     = 16;

  localparam logic [TICK_W-1:0]  ELAPSED_MAX  = 15'd32767;
  localparam logic [TICK_W-1:0]  DELAY_RESET  = 15'd180;
  localparam logic [TICK_W-1:0]  TICKS_PER_U  = 15'd100;
  localparam logic [7:0]         IVL_RESET    = 8'd14;
  localparam logic [7:0]         IVL_ALIAS    = 8'd255;
  localparam logic [7:0]         MIN_CMD_LEN  = 8'd6;
  localparam logic [LEVEL_W-1:0] LEVEL_OFF    = 8'd255;
  // x / 20 = (x * 52429) >> 20 for any 16-bit x
  localparam logic [15:0]        DIV20_MUL    = 16'd52429;
  localparam int                 DIV20_SHIFT  = 20;

  localparam logic       MODE_TICK = 1'b0;
  localparam logic [1:0] CMD_LE    = 2'd0;
  localparam logic [1:0] CMD_GE    = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SAMPLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/brightness_average_threshold_switch_unit.sv =====
// top level of the brightness average threshold switch: sequencer, timing and flags
// depends on bats_pkg, bats_ring, bats_div
//
// usage
//   s_axis carries one item: a 100 ms tick with the analog value (tuser = 0) or a
//   link command (tuser = 1). every item yields exactly one result item on m_axis
//   with the averaged level and the active, less-equal and blocking flags.
//   cfg_we / cfg_wdata write the interval register (10 s units, 255 stored as 14,
//   0 disables); a write reloads the delay. the user must make the write only
//   while the block is idle; the block itself does not enforce this.
// sequencing
//   one item at a time; s_axis_tready is high only while the sequencer is idle.
//   a command or a tick that takes no sample passes EXEC and DONE; a tick that
//   takes a sample passes EXEC, SAMPLE, DIV_START, DIV_WAIT and DONE, and in
//   DIV_WAIT the restoring divider forms sum / fill count one bit per cycle.
// reset
//   rst is synchronous: window empty, level 0, flags clear, delay 180 ticks,
//   interval 14, no result pending.
// stall
//   a result waits in the output register until m_axis_tready; the next item is
//   taken meanwhile, and its result waits in the sequencer until the register frees.

module brightness_average_threshold_switch_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // analog_value[15:0], cmd_length[23:16], command[25:24], cond_level[33:26],
  // block_time[41:34], zero fill
  input  logic [bats_pkg::IN_W-1:0]   s_axis_tdata,
  // mode[0]
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // level[7:0], active[8], less_equal_hit[9], blocking[10], zero fill
  output logic [bats_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                        cfg_we,
  input  logic [7:0]                  cfg_wdata
);

  bats_pkg::state_t state, state_next;

  logic                           it_mode;
  logic [bats_pkg::RAW_W-1:0]     it_raw;
  logic [7:0]                     it_len;
  logic [1:0]                     it_cmd;
  logic [7:0]                     it_cond;
  logic [7:0]                     it_blk;

  logic [7:0]                     interval;
  logic [bats_pkg::TICK_W-1:0]    elapsed;
  logic [bats_pkg::TICK_W-1:0]    delay;
  logic [bats_pkg::LEVEL_W-1:0]   avg_level;
  logic                           f_active;
  logic                           f_le;
  logic                           f_block;
  logic [11:0]                    reading_q;

  logic [bats_pkg::TICK_W-1:0]    elapsed_inc;
  logic                           due;
  logic [31:0]                    product;
  logic [bats_pkg::LEVEL_W-1:0]   reading;
  logic [7:0]                     cfg_ivl;
  logic                           out_free;
  logic                           cmd_ok;
  logic                           le_hit;
  logic                           ge_hit;

  logic [bats_pkg::SUM_W-1:0]     win_sum;
  logic [bats_pkg::FILL_W-1:0]    win_filled;
  logic [bats_pkg::SUM_W-1:0]     quotient;
  bats_pkg::div_stat_t            div_stat;

  assign s_axis_tready = state == bats_pkg::ST_IDLE;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign elapsed_inc = (elapsed == bats_pkg::ELAPSED_MAX) ? elapsed : elapsed + 1'b1;
  assign due         = elapsed_inc >= delay;
  assign product     = 32'(it_raw) * 32'(bats_pkg::DIV20_MUL);
  assign reading     = (reading_q > 12'(bats_pkg::READ_MAX)) ?
                       bats_pkg::LEVEL_W'(bats_pkg::READ_MAX) :
                       bats_pkg::LEVEL_W'(reading_q);
  assign cfg_ivl     = (cfg_wdata == bats_pkg::IVL_ALIAS) ? bats_pkg::IVL_RESET : cfg_wdata;
  assign cmd_ok      = (win_filled != '0) && (it_len >= bats_pkg::MIN_CMD_LEN);
  assign le_hit      = (it_cmd == bats_pkg::CMD_LE) && (avg_level <= it_cond);
  assign ge_hit      = (it_cmd == bats_pkg::CMD_GE) && (avg_level >= it_cond);

  bats_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (state == bats_pkg::ST_SAMPLE),
    .reading (reading),
    .sum     (win_sum),
    .filled  (win_filled)
  );

  bats_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == bats_pkg::ST_DIV_START),
    .dividend (win_sum),
    .divisor  (win_filled),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bats_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bats_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = bats_pkg::ST_EXEC;
        end
      end
      bats_pkg::ST_EXEC: begin
        if (it_mode == bats_pkg::MODE_TICK && delay != '0 && due) begin
          state_next = bats_pkg::ST_SAMPLE;
        end else begin
          state_next = bats_pkg::ST_DONE;
        end
      end
      bats_pkg::ST_SAMPLE:    state_next = bats_pkg::ST_DIV_START;
      bats_pkg::ST_DIV_START: state_next = bats_pkg::ST_DIV_WAIT;
      bats_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = bats_pkg::ST_DONE;
        end
      end
      bats_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = bats_pkg::ST_IDLE;
        end
      end
      default: state_next = bats_pkg::ST_IDLE;
    endcase
  end

  // item capture and sample arithmetic
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      it_mode <= s_axis_tuser;
      it_raw  <= s_axis_tdata[15:0];
      it_len  <= s_axis_tdata[23:16];
      it_cmd  <= s_axis_tdata[25:24];
      it_cond <= s_axis_tdata[33:26];
      it_blk  <= s_axis_tdata[41:34];
    end
    if (state == bats_pkg::ST_EXEC) begin
      reading_q <= product[bats_pkg::DIV20_SHIFT +: 12];
    end
  end

  // timing, level and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      interval  <= bats_pkg::IVL_RESET;
      elapsed   <= '0;
      delay     <= bats_pkg::DELAY_RESET;
      avg_level <= '0;
      f_active  <= 1'b0;
      f_le      <= 1'b0;
      f_block   <= 1'b0;
    end else begin
      if (state == bats_pkg::ST_EXEC) begin
        if (it_mode == bats_pkg::MODE_TICK) begin
          if (delay == '0) begin
            avg_level <= bats_pkg::LEVEL_OFF;
          end else if (due) begin
            elapsed <= '0;
            if (f_block) begin
              f_block <= 1'b0;
              delay   <= bats_pkg::TICK_W'(interval) * bats_pkg::TICKS_PER_U;
            end
          end else begin
            elapsed <= elapsed_inc;
          end
        end else if (cmd_ok) begin
          f_active <= le_hit || ge_hit;
          if (le_hit) begin
            f_le <= 1'b1;
          end else if (ge_hit) begin
            f_le <= 1'b0;
          end
          if (le_hit || ge_hit) begin
            if (it_blk != '0) begin
              delay   <= bats_pkg::TICK_W'(it_blk) * bats_pkg::TICKS_PER_U;
              elapsed <= '0;
              f_block <= 1'b1;
            end else begin
              f_block <= 1'b0;
            end
          end
        end
      end
      if (state == bats_pkg::ST_DIV_WAIT && div_stat.done) begin
        avg_level <= quotient[bats_pkg::LEVEL_W-1:0];
      end
      if (cfg_we) begin
        interval <= cfg_ivl;
        delay    <= bats_pkg::TICK_W'(cfg_ivl) * bats_pkg::TICKS_PER_U;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == bats_pkg::ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bats_pkg::ST_DONE && out_free) begin
      m_axis_tdata <= {5'b0, f_block, f_le, f_active, avg_level};
    end
  end

endmodule

// ===== rtl/core/bats_div.sv =====
// iterative restoring divider: window sum over fill count, one quotient bit a cycle
// depends on bats_pkg

module bats_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bats_pkg::SUM_W-1:0]  dividend,
  input  logic [bats_pkg::FILL_W-1:0] divisor,
  output logic [bats_pkg::SUM_W-1:0]  quotient,
  output bats_pkg::div_stat_t         stat
);

  logic [bats_pkg::FILL_W-1:0] rem;
  logic [bats_pkg::SUM_W-1:0]  quo;
  logic [bats_pkg::FILL_W-1:0] dvs;
  logic [bats_pkg::CNT_W-1:0]  cnt;
  logic                        done;
  logic [bats_pkg::FILL_W:0]   shifted;
  logic                        fits;

  assign shifted = {rem, quo[bats_pkg::SUM_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= bats_pkg::CNT_W'(bats_pkg::SUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == bats_pkg::CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != '0) begin
      if (fits) begin
        rem <= bats_pkg::FILL_W'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[bats_pkg::FILL_W-1:0];
      end
      quo <= {quo[bats_pkg::SUM_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign stat.busy = cnt != '0;
  assign stat.done = done;

endmodule

// ===== rtl/core/bats_ring.sv =====
// sample window: ring of readings, running sum, write position and fill count
// depends on bats_pkg

module bats_ring (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [bats_pkg::LEVEL_W-1:0]        reading,
  output logic [bats_pkg::SUM_W-1:0]          sum,
  output logic [bats_pkg::FILL_W-1:0]         filled
);

  logic [bats_pkg::LEVEL_W-1:0] ring [bats_pkg::SAMPLES];
  logic [bats_pkg::POS_W-1:0]   pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bats_pkg::SAMPLES; i++) begin
        ring[i] <= '0;
      end
      sum    <= '0;
      pos    <= '0;
      filled <= '0;
    end else if (wr_en) begin
      ring[pos] <= reading;
      sum       <= sum - bats_pkg::SUM_W'(ring[pos]) + bats_pkg::SUM_W'(reading);
      if (pos == bats_pkg::POS_W'(bats_pkg::SAMPLES - 1)) begin
        pos <= '0;
      end else begin
        pos <= pos + 1'b1;
      end
      if (filled != bats_pkg::FILL_W'(bats_pkg::SAMPLES)) begin
        filled <= filled + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/bats_checker.sv =====
// port-level checks for the brightness average threshold switch, bound to the top level
// depends on brightness_average_threshold_switch_unit and bats_pkg

module bats_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [bats_pkg::OUT_W-1:0]  m_axis_tdata
);

  logic in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready && !$rose(m_axis_tvalid))
    else $error("item taken or result shown right after an accept");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:0] <= 8'd200 || m_axis_tdata[7:0] == 8'd255))
    else $error("level outside averaged range");

endmodule

bind brightness_average_threshold_switch_unit bats_checker u_bats_checker (.*);
